// ----- rtl/aflm_pkg.sv -----
// ----------------------------------------------------------------------------
// aflm_pkg: shared types and constants of the attitude filter and motor mixer
// Holds the data formats, the CORDIC angle table, the controller and
// datapath command types and the configuration register indexes.
// ----------------------------------------------------------------------------
package aflm_pkg;

  // Data format: signed Q(32-FRAC_BITS).FRAC_BITS.
  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
  localparam longint ANG_RND  = (ANG_SH > 0) ? (64'sd1 <<< ((ANG_SH > 0) ? ANG_SH - 1 : 0)) : 0;
  localparam int MOTOR_SH     = FRAC_BITS + 8;

  // Iteration counts.
  localparam int STEP_W       = 5;
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 32;
  localparam int NUM_TERMS    = 5;
  localparam int NUM_MOTORS   = 4;

  // Internal widths.
  localparam int CW     = 60;  // CORDIC x and y
  localparam int ZW     = 35;  // CORDIC angle, Q.24 degrees
  localparam int AW     = 59;  // LQR term accumulators
  localparam int MUL_W  = 34;  // shared multiplier operands
  localparam int PROD_W = 64;  // kept product bits
  localparam int DD_W   = 23;  // gyro angle increment
  localparam int S_W    = 50;  // first blend product

  localparam logic signed [ZW-1:0] DEG180_Q24 = 35'sd3019898880;
  localparam logic [22:0] H_Q32 = 23'd4294967;

  // Motor sign pattern: a set bit k means the term enters motor k negated.
  localparam logic [NUM_MOTORS-1:0] NEG_ANGLE_R = 4'b0011;
  localparam logic [NUM_MOTORS-1:0] NEG_ANGLE_P = 4'b1001;
  localparam logic [NUM_MOTORS-1:0] NEG_YAW     = 4'b0101;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_ROLL       = 3'd0,
    CFG_GAIN_PITCH      = 3'd1,
    CFG_GAIN_YAW        = 3'd2,
    CFG_GAIN_ROLL_RATE  = 3'd3,
    CFG_GAIN_PITCH_RATE = 3'd4,
    CFG_GAIN_YAW_RATE   = 3'd5,
    CFG_THRUST_SCALE    = 3'd6,
    CFG_BLEND_FACTOR    = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_B,
    ST_SQ_C,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_ANGLE_SAVE,
    ST_BL_D,
    ST_BL_M1,
    ST_BL_M2,
    ST_BL_FIN,
    ST_ERR,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_MIX,
    ST_MUL_U,
    ST_MOTOR,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SQ_B,
    OP_SQ_C,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_CORDIC_INIT,
    OP_CORDIC,
    OP_ANGLE_SAVE,
    OP_BL_D,
    OP_BL_M1,
    OP_BL_M2,
    OP_BL_FIN,
    OP_ERR,
    OP_TERM_MUL,
    OP_TERM_ACC,
    OP_MIX,
    OP_MUL_U,
    OP_MOTOR,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic              axis;  // 0 roll, 1 pitch
    logic [STEP_W-1:0] step;
    logic              load;  // capture the input word
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;  // result register holds a word that is being stalled
  } dp_status_t;

  // atan(2^-i) in Q.24 degrees.
  function automatic logic [29:0] atan_q24(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      5'd24:   v = 30'd57;
      5'd25:   v = 30'd29;
      5'd26:   v = 30'd14;
      5'd27:   v = 30'd7;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Saturate a 64-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/aflm_ctrl.sv -----
// ----------------------------------------------------------------------------
// aflm_ctrl: sequencer of the attitude filter and motor mixer
// Steps one item through the datapath operations and counts the iterations
// of the square root, the CORDIC and the LQR term and motor loops.
// ----------------------------------------------------------------------------
module aflm_ctrl import aflm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              axis_q, axis_d;

  // State, step counter and axis select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        axis_d = 1'b0;
        if (in_valid_i) begin
          state_d = in_kind_i ? ST_ERR : ST_SQ_B;
        end
      end
      ST_SQ_B:      state_d = ST_SQ_C;
      ST_SQ_C:      state_d = ST_SQRT_INIT;
      ST_SQRT_INIT: begin
        state_d = ST_SQRT;
        step_d  = '0;
      end
      ST_SQRT: begin
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_CORDIC_INIT;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_CORDIC_INIT: begin
        state_d = ST_CORDIC;
        step_d  = '0;
      end
      ST_CORDIC: begin
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_ANGLE_SAVE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ANGLE_SAVE: begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_CORDIC_INIT;
        end else begin
          axis_d  = 1'b0;
          state_d = ST_BL_D;
        end
      end
      ST_BL_D:  state_d = ST_BL_M1;
      ST_BL_M1: state_d = ST_BL_M2;
      ST_BL_M2: state_d = ST_BL_FIN;
      ST_BL_FIN: begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_BL_D;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        state_d = ST_TERM_MUL;
        step_d  = '0;
      end
      ST_TERM_MUL: state_d = ST_TERM_ACC;
      ST_TERM_ACC: begin
        if (step_q == STEP_W'(NUM_TERMS - 1)) begin
          state_d = ST_MIX;
          step_d  = '0;
        end else begin
          state_d = ST_TERM_MUL;
          step_d  = step_q + 1'b1;
        end
      end
      ST_MIX:   state_d = ST_MUL_U;
      ST_MUL_U: state_d = ST_MOTOR;
      ST_MOTOR: begin
        if (step_q == STEP_W'(NUM_MOTORS - 1)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MIX;
          step_d  = step_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.axis = axis_q;
    cmd_o.step = step_q;
    cmd_o.load = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SQ_B:        cmd_o.op = OP_SQ_B;
      ST_SQ_C:        cmd_o.op = OP_SQ_C;
      ST_SQRT_INIT:   cmd_o.op = OP_SQRT_INIT;
      ST_SQRT:        cmd_o.op = OP_SQRT;
      ST_CORDIC_INIT: cmd_o.op = OP_CORDIC_INIT;
      ST_CORDIC:      cmd_o.op = OP_CORDIC;
      ST_ANGLE_SAVE:  cmd_o.op = OP_ANGLE_SAVE;
      ST_BL_D:        cmd_o.op = OP_BL_D;
      ST_BL_M1:       cmd_o.op = OP_BL_M1;
      ST_BL_M2:       cmd_o.op = OP_BL_M2;
      ST_BL_FIN:      cmd_o.op = OP_BL_FIN;
      ST_ERR:         cmd_o.op = OP_ERR;
      ST_TERM_MUL:    cmd_o.op = OP_TERM_MUL;
      ST_TERM_ACC:    cmd_o.op = OP_TERM_ACC;
      ST_MIX:         cmd_o.op = OP_MIX;
      ST_MUL_U:       cmd_o.op = OP_MUL_U;
      ST_MOTOR:       cmd_o.op = OP_MOTOR;
      ST_OUT:         cmd_o.op = status_i.out_full ? OP_NONE : OP_OUT;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/aflm_dp.sv -----
// ----------------------------------------------------------------------------
// aflm_dp: datapath of the attitude filter and motor mixer
// One shared multiplier, a bit-pair square root, a CORDIC vectoring unit,
// the filter and LQR state, the configuration registers and the result
// register.
// ----------------------------------------------------------------------------
module aflm_dp import aflm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  input  logic signed [31:0]            in_a_i,
  input  logic signed [31:0]            in_b_i,
  input  logic signed [31:0]            in_c_i,
  input  logic signed [31:0]            in_d_i,
  input  logic signed [31:0]            in_e_i,
  input  logic signed [31:0]            in_f_i,
  input  logic [15:0]                   thrust_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [NUM_MOTORS-1:0][15:0]   motor_o
);

  // Configuration registers. The yaw angle gain multiplies a zero error,
  // so it is not kept.
  logic [31:0] gain_roll_q, gain_pitch_q, gain_rr_q, gain_pr_q, gain_yr_q;
  logic [23:0] ts_q;
  logic [15:0] blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_roll_q  <= 32'd10414885;
      gain_pitch_q <= 32'd10559009;
      gain_rr_q    <= 32'd1483302;
      gain_pr_q    <= 32'd2196482;
      gain_yr_q    <= 32'd3462;
      ts_q         <= 24'd1987900;
      blend_q      <= 16'd64880;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_ROLL:       gain_roll_q  <= cfg_data_i;
        CFG_GAIN_PITCH:      gain_pitch_q <= cfg_data_i;
        CFG_GAIN_YAW:        ;
        CFG_GAIN_ROLL_RATE:  gain_rr_q    <= cfg_data_i;
        CFG_GAIN_PITCH_RATE: gain_pr_q    <= cfg_data_i;
        CFG_GAIN_YAW_RATE:   gain_yr_q    <= cfg_data_i;
        CFG_THRUST_SCALE:    ts_q         <= cfg_data_i[23:0];
        CFG_BLEND_FACTOR:    blend_q      <= cfg_data_i[15:0];
        default:             ;
      endcase
    end
  end

  // Input word capture.
  logic signed [31:0] in_a_q, in_b_q, in_c_q, in_d_q, in_e_q, in_f_q;
  logic [15:0]        thr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_a_q <= in_a_i;
      in_b_q <= in_b_i;
      in_c_q <= in_c_i;
      in_d_q <= in_d_i;
      in_e_q <= in_e_i;
      in_f_q <= in_f_i;
      thr_q  <= thrust_i;
    end
  end

  // Filter state and latched rates.
  logic signed [31:0] roll_est_q, pitch_est_q, rr_q, pr_q, yr_q;

  // Working registers.
  logic signed [PROD_W-1:0] p_q;
  logic [63:0]              sqv_q, rt_q, bit_q;
  logic signed [CW-1:0]     cx_q, cy_q;
  logic signed [ZW-1:0]     cz_q;
  logic                     czero_q;
  logic signed [31:0]       ang_roll_q, ang_pitch_q;
  logic signed [DD_W-1:0]   dd_q;
  logic signed [S_W-1:0]    s_q;
  logic signed [31:0]       err_q [NUM_TERMS];
  logic signed [AW-1:0]     acc_r_q, acc_p_q, acc_y_q;
  logic signed [31:0]       u_q;
  logic [15:0]              motor_q [NUM_MOTORS];
  logic [NUM_MOTORS-1:0][15:0] out_q;
  logic                     out_valid_q;

  // Shared multiplier operand selection.
  logic [16:0]              one_minus_g;
  logic signed [31:0]       est_sel, ang_sel, rate_sel;
  logic signed [32:0]       est_sum;
  logic [31:0]              gain_sel;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;

  assign one_minus_g = 17'h10000 - {1'b0, blend_q};
  assign est_sel     = cmd_i.axis ? pitch_est_q : roll_est_q;
  assign ang_sel     = cmd_i.axis ? ang_pitch_q : ang_roll_q;
  assign rate_sel    = cmd_i.axis ? in_e_q : in_d_q;
  assign est_sum     = 33'(est_sel) + 33'(dd_q);

  always_comb begin
    case (cmd_i.step)
      5'd0:    gain_sel = gain_roll_q;
      5'd1:    gain_sel = gain_pitch_q;
      5'd2:    gain_sel = gain_rr_q;
      5'd3:    gain_sel = gain_pr_q;
      default: gain_sel = gain_yr_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ_B: begin
        mul_a = MUL_W'(in_b_q);
        mul_b = MUL_W'(in_b_q);
      end
      OP_SQ_C: begin
        mul_a = MUL_W'(in_c_q);
        mul_b = MUL_W'(in_c_q);
      end
      OP_BL_D: begin
        mul_a = MUL_W'(rate_sel);
        mul_b = MUL_W'(H_Q32);
      end
      OP_BL_M1: begin
        mul_a = MUL_W'(one_minus_g);
        mul_b = MUL_W'(ang_sel);
      end
      OP_BL_M2: begin
        mul_a = MUL_W'(blend_q);
        mul_b = MUL_W'(est_sum);
      end
      OP_TERM_MUL: begin
        mul_a = MUL_W'(gain_sel);
        mul_b = MUL_W'(err_q[cmd_i.step[2:0]]);
      end
      OP_MUL_U: begin
        mul_a = MUL_W'(ts_q);
        mul_b = MUL_W'(u_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    p_q <= $signed(mul_full[PROD_W-1:0]);
  end

  // Square root, two radicand bits per pass.
  logic [63:0] rb;
  assign rb = rt_q + bit_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SQ_C: sqv_q <= unsigned'(p_q);
      OP_SQRT_INIT: begin
        sqv_q <= sqv_q + unsigned'(p_q);
        rt_q  <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sqv_q >= rb) begin
          sqv_q <= sqv_q - rb;
          rt_q  <= (rt_q >> 1) + bit_q;
        end else begin
          rt_q  <= rt_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  // CORDIC vectoring; axis 0 is atan2(ay, az), axis 1 is atan2(-ax, r).
  logic signed [33:0]   cx_in, cy_in;
  logic signed [CW-1:0] cx_sh, cy_sh, cx_sr, cy_sr;
  logic signed [ZW-1:0] atan_v, zr;

  assign cx_in  = cmd_i.axis ? $signed({2'b00, rt_q[31:0]}) : 34'(in_c_q);
  assign cy_in  = cmd_i.axis ? -(34'(in_a_q)) : 34'(in_b_q);
  assign cx_sh  = CW'(cx_in) <<< ANG_FRAC;
  assign cy_sh  = CW'(cy_in) <<< ANG_FRAC;
  assign cx_sr  = cx_q >>> cmd_i.step;
  assign cy_sr  = cy_q >>> cmd_i.step;
  assign atan_v = $signed(ZW'(atan_q24(cmd_i.step)));
  assign zr     = (cz_q + ZW'(ANG_RND)) >>> ANG_SH;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CORDIC_INIT: begin
        czero_q <= (cx_in == '0) && (cy_in == '0);
        if (cx_in < 0) begin
          cx_q <= -cx_sh;
          cy_q <= -cy_sh;
          cz_q <= (cy_in >= 0) ? DEG180_Q24 : -DEG180_Q24;
        end else begin
          cx_q <= cx_sh;
          cy_q <= cy_sh;
          cz_q <= '0;
        end
      end
      OP_CORDIC: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cy_sr;
          cy_q <= cy_q - cx_sr;
          cz_q <= cz_q + atan_v;
        end else begin
          cx_q <= cx_q - cy_sr;
          cy_q <= cy_q + cx_sr;
          cz_q <= cz_q - atan_v;
        end
      end
      default: ;
    endcase
  end

  // Accelerometer angles, rounded to the data format.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ANGLE_SAVE) begin
      if (cmd_i.axis) begin
        ang_pitch_q <= czero_q ? '0 : sat32(64'(zr));
      end else begin
        ang_roll_q  <= czero_q ? '0 : sat32(64'(zr));
      end
    end
  end

  // Complementary filter: gyro increment, then the two weighted products.
  logic signed [63:0] dd_full, blend_tot;
  assign dd_full   = (p_q + (64'sd1 <<< 31)) >>> 32;
  assign blend_tot = 64'(s_q) + p_q + 64'sd32768;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_BL_M1: dd_q <= dd_full[DD_W-1:0];
      OP_BL_M2: s_q  <= p_q[S_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_est_q  <= '0;
      pitch_est_q <= '0;
      rr_q        <= '0;
      pr_q        <= '0;
      yr_q        <= '0;
    end else if (cmd_i.op == OP_BL_FIN) begin
      if (cmd_i.axis) begin
        pitch_est_q <= sat32(blend_tot >>> 16);
        rr_q        <= in_d_q;
        pr_q        <= in_e_q;
        yr_q        <= in_f_q;
      end else begin
        roll_est_q  <= sat32(blend_tot >>> 16);
      end
    end
  end

  // LQR errors, term accumulation and motor mixing.
  logic signed [63:0]   term_full, motor_full;
  logic signed [AW-1:0] term, mix_sum;
  logic [1:0]           mk;

  assign mk        = cmd_i.step[1:0];
  assign term_full = p_q >>> 8;
  assign term      = term_full[AW-1:0];
  assign mix_sum   = (NEG_ANGLE_R[mk] ? -acc_r_q : acc_r_q)
                   + (NEG_ANGLE_P[mk] ? -acc_p_q : acc_p_q)
                   + (NEG_YAW[mk]     ? -acc_y_q : acc_y_q);
  // The thrust is zero extended as a signed operand so the shift stays arithmetic.
  assign motor_full = (p_q >>> MOTOR_SH) + $signed({48'd0, thr_q});

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ERR: begin
        err_q[0] <= sat32(64'(in_a_q) - 64'(roll_est_q));
        err_q[1] <= sat32(64'(in_b_q) - 64'(pitch_est_q));
        err_q[2] <= sat32(64'(in_c_q) - 64'(rr_q));
        err_q[3] <= sat32(64'(in_d_q) - 64'(pr_q));
        err_q[4] <= sat32(64'(in_e_q) - 64'(yr_q));
        acc_r_q  <= '0;
        acc_p_q  <= '0;
        acc_y_q  <= '0;
      end
      OP_TERM_ACC: begin
        case (cmd_i.step)
          5'd0, 5'd2: acc_r_q <= acc_r_q + term;
          5'd1, 5'd3: acc_p_q <= acc_p_q + term;
          default:    acc_y_q <= acc_y_q + term;
        endcase
      end
      OP_MIX: u_q <= sat32(64'(mix_sum) >>> 16);
      OP_MOTOR: begin
        if (motor_full < 0) begin
          motor_q[mk] <= 16'd0;
        end else if (motor_full > 64'sd65535) begin
          motor_q[mk] <= 16'hFFFF;
        end else begin
          motor_q[mk] <= motor_full[15:0];
        end
      end
      default: ;
    endcase
  end

  // Result register, loaded only when it is empty or being taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        out_q[k] <= motor_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign motor_o           = out_q;

endmodule

// ----- rtl/attitude_filter_lqr_motor_mixer.sv -----
// ----------------------------------------------------------------------------
// attitude_filter_lqr_motor_mixer: attitude estimator and LQR motor mixer
// Sensor words update the roll and pitch estimates; control words give four
// saturated motor values.
//
//   channel | handshake                    | word
//   --------+------------------------------+-----------------------------------
//   input   | in_valid_i / in_stall_o      | kind, six Q16.16 fields, thrust
//   output  | out_valid_o / out_stall_i    | motor_1..motor_4
//   config  | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A sensor word runs the squares, 32 square root passes, two CORDIC runs
// and the filter steps of both axes, all on one shared multiplier and one
// CORDIC unit. A control word runs the errors, 5 gain products and 4 motors,
// then the result load.
// One word is in work at a time; the next one is taken while a result waits.
// Reset restores the gains and clears the estimates; no clearing pass.
// ----------------------------------------------------------------------------
module attitude_filter_lqr_motor_mixer import aflm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic signed [31:0]   accel_x_or_roll_ref_i,
  input  logic signed [31:0]   accel_y_or_pitch_ref_i,
  input  logic signed [31:0]   accel_z_or_roll_rate_ref_i,
  input  logic signed [31:0]   gyro_x_or_pitch_rate_ref_i,
  input  logic signed [31:0]   gyro_y_or_yaw_rate_ref_i,
  input  logic signed [31:0]   gyro_z_i,
  input  logic [15:0]          thrust_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          motor_1_o,
  output logic [15:0]          motor_2_o,
  output logic [15:0]          motor_3_o,
  output logic [15:0]          motor_4_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  dp_cmd_t                     cmd;
  dp_status_t                  status;
  logic [NUM_MOTORS-1:0][15:0] motor;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  aflm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  aflm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_a_i      (accel_x_or_roll_ref_i),
    .in_b_i      (accel_y_or_pitch_ref_i),
    .in_c_i      (accel_z_or_roll_rate_ref_i),
    .in_d_i      (gyro_x_or_pitch_rate_ref_i),
    .in_e_i      (gyro_y_or_yaw_rate_ref_i),
    .in_f_i      (gyro_z_i),
    .thrust_i    (thrust_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .motor_o     (motor)
  );

  assign motor_1_o = motor[0];
  assign motor_2_o = motor[1];
  assign motor_3_o = motor[2];
  assign motor_4_o = motor[3];

endmodule

// ----- rtl/aflm_chk.sv -----
// ----------------------------------------------------------------------------
// aflm_chk: port checker of the attitude filter and motor mixer
// Watches the top level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module aflm_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 kind_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [15:0]          motor_1_o,
  input logic [15:0]          motor_2_o,
  input logic [15:0]          motor_3_o,
  input logic [15:0]          motor_4_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_1_o)
      && $stable(motor_2_o) && $stable(motor_3_o) && $stable(motor_4_o))
    else $error("result word changed while stalled");

  // After taking a word the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result appears only at the end of work on a word.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

  // A sensor word never raises a result on the next cycle.
  a_sensor_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !kind_i |=> !$rose(out_valid_o))
    else $error("result raised by a sensor word");

endmodule

bind attitude_filter_lqr_motor_mixer aflm_chk u_aflm_chk (.*);
